@@ rtl/core/vai_pkg.sv @@
// Shared types and constants for the vertex attribute interpolator.
// Used by vai_store and vertex_attribute_interpolator; no dependencies.
`default_nettype none

package vai_pkg;

    localparam int VERTEX_DEPTH = 256;
    localparam int VTX_AW       = $clog2(VERTEX_DEPTH);
    localparam int IDX_W        = 8;
    localparam int N_SRC        = 3;
    localparam int N_ATTR       = 9;
    localparam int WGT_W        = 19;  // q2.16 weights widened for 1 - t
    localparam int ATT_W        = 17;  // int16 or zero-extended channel
    localparam int PRD_W        = 36;
    localparam int SUM_W        = 38;
    localparam int Q_W          = SUM_W - 15;  // rounded sum (SUM_W + 1 bits) with the 16 fraction bits dropped
    localparam int IN_TDATA_W   = 200;
    localparam int OUT_TDATA_W  = 120;
    localparam int ONE_Q16      = 65536;
    localparam int HALF_Q16     = 32768;
    localparam int CHAN_MAX     = 255;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_LERP  = 2'd2,
        MODE_BARY  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [31:0] color;
        logic [15:0] v;
        logic [15:0] u;
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } t_vertex;

    typedef struct packed {
        logic              en;
        logic [VTX_AW-1:0] addr;
        t_vertex           data;
    } t_store_wr;

endpackage

`default_nettype wire

@@ rtl/core/vertex_attribute_interpolator.sv @@
// Top level of the vertex attribute interpolator: stream ports, pipeline,
// weighting and rounding. Depends on vai_pkg and vai_store.
`default_nettype none

// Takes one beat per cycle unless the output stalls or a hazard holds the input
// register, and returns one beat per item, in order; an accepted item passes the
// input register, store read, products, then sum and rounding into the output register.
// The store is held in three copies so a, b and c are read in the same cycle.
// An item that reads a slot which one of the two items ahead of it will write
// waits in the input register until that write lands.
// Reset clears the store at once through per-entry valid bits; no clearing pass.
// While a result waits at the output the whole pipeline holds; only an empty
// input register still takes one beat.
module vertex_attribute_interpolator
    import vai_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // a_index, b_index, c_index, result_index, weight_a, weight_b, weight_c,
    // in_pos, in_uv, in_color, zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // mode
    input  wire logic [1:0]             i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // out_index, out_pos, out_uv, out_color
    output logic [OUT_TDATA_W-1:0]      o_m_tdata
);

    // ---------------------------------------------------------------- helpers
    function automatic logic signed [ATT_W-1:0] attr_of(t_vertex vx, logic [3:0] k);
        logic signed [ATT_W-1:0] a;
        case (k)
            0:       a = ATT_W'($signed(vx.x));
            1:       a = ATT_W'($signed(vx.y));
            2:       a = ATT_W'($signed(vx.z));
            3:       a = ATT_W'($signed(vx.u));
            4:       a = ATT_W'($signed(vx.v));
            5:       a = ATT_W'({1'b0, vx.color[7:0]});
            6:       a = ATT_W'({1'b0, vx.color[15:8]});
            7:       a = ATT_W'({1'b0, vx.color[23:16]});
            default: a = ATT_W'({1'b0, vx.color[31:24]});
        endcase
        return a;
    endfunction

    function automatic logic [15:0] sat16(logic signed [Q_W-1:0] q);
        logic [15:0] r;
        if (q > Q_W'(32767)) begin
            r = 16'h7fff;
        end else if (q < Q_W'(-32768)) begin
            r = 16'h8000;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

    // truncate toward zero
    function automatic logic [15:0] to_pos(logic signed [SUM_W-1:0] s);
        logic signed [Q_W-1:0] q;
        q = Q_W'(s >>> 16);
        if (s[SUM_W-1] && (s[15:0] != 16'd0)) begin
            q = q + Q_W'(1);
        end
        return sat16(q);
    endfunction

    // nearest, halves upward
    function automatic logic [15:0] to_uv(logic signed [SUM_W-1:0] s);
        logic signed [SUM_W:0] t;
        t = (SUM_W + 1)'(s) + (SUM_W + 1)'(HALF_Q16);
        return sat16(Q_W'(t >>> 16));
    endfunction

    function automatic logic [7:0] to_chan(logic signed [SUM_W-1:0] s);
        logic signed [SUM_W:0]  t;
        logic signed [Q_W-1:0]  q;
        logic [7:0]             r;
        t = (SUM_W + 1)'(s) + (SUM_W + 1)'(HALF_Q16);
        q = Q_W'(t >>> 16);
        if (t[SUM_W]) begin
            r = 8'd0;
        end else if (q > Q_W'(CHAN_MAX)) begin
            r = 8'(CHAN_MAX);
        end else begin
            r = q[7:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- control
    logic adv;
    logic hazard;
    logic in_beat;

    // stage 1: input register
    logic                          r_s1_vld;
    logic [N_SRC-1:0][VTX_AW-1:0]  r_s1_src;
    logic [N_SRC-1:0]              r_s1_use;
    logic                          r_s1_wr;
    logic                          r_s1_use_in;
    logic [VTX_AW-1:0]             r_s1_oidx;
    logic signed [WGT_W-1:0]       r_s1_w [N_SRC];
    t_vertex                       r_s1_vtx;

    logic [N_SRC-1:0]              n_s1_use;
    logic                          n_s1_wr;
    logic                          n_s1_use_in;
    logic [VTX_AW-1:0]             n_s1_oidx;
    logic signed [WGT_W-1:0]       n_s1_w [N_SRC];

    // stage 2: store read data
    logic                          r_s2_vld;
    logic                          r_s2_wr;
    logic                          r_s2_use_in;
    logic [VTX_AW-1:0]             r_s2_oidx;
    logic signed [WGT_W-1:0]       r_s2_w [N_SRC];
    t_vertex                       r_s2_vtx;
    t_vertex [N_SRC-1:0]           rd_data;
    t_vertex                       s2_src [N_SRC];

    // stage 3: products
    logic                          r_s3_vld;
    logic                          r_s3_wr;
    logic [VTX_AW-1:0]             r_s3_oidx;
    logic signed [PRD_W-1:0]       r_s3_prod [N_ATTR][N_SRC];
    logic signed [PRD_W-1:0]       n_s3_prod [N_ATTR][N_SRC];
    logic signed [SUM_W-1:0]       s3_sum [N_ATTR];
    t_vertex                       n_res;

    // output register
    logic                          r_out_vld;
    logic [VTX_AW-1:0]             r_out_oidx;
    t_vertex                       r_out_vtx;

    t_store_wr                     st_wr;
    t_mode                         in_mode;

    assign in_mode    = t_mode'(i_s_tuser);
    assign adv        = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_s1_vld || (adv && !hazard);
    assign in_beat    = i_s_tvalid && o_s_tready;

    // ------------------------------------------------------------ input decode
    always_comb begin
        n_s1_use    = '0;
        n_s1_wr     = 1'b1;
        n_s1_use_in = 1'b0;
        n_s1_oidx   = VTX_AW'(i_s_tdata[31:24]);
        n_s1_w[0]   = WGT_W'(ONE_Q16);
        n_s1_w[1]   = '0;
        n_s1_w[2]   = '0;
        case (in_mode)
            MODE_WRITE: begin
                n_s1_use_in = 1'b1;
            end
            MODE_READ: begin
                n_s1_use  = 3'b001;
                n_s1_wr   = 1'b0;
                n_s1_oidx = VTX_AW'(i_s_tdata[7:0]);
            end
            MODE_LERP: begin
                n_s1_use  = 3'b011;
                n_s1_w[1] = WGT_W'($signed(i_s_tdata[67:50]));
                n_s1_w[0] = WGT_W'(ONE_Q16) - WGT_W'($signed(i_s_tdata[67:50]));
            end
            MODE_BARY: begin
                n_s1_use  = 3'b111;
                n_s1_w[0] = WGT_W'($signed(i_s_tdata[49:32]));
                n_s1_w[1] = WGT_W'($signed(i_s_tdata[67:50]));
                n_s1_w[2] = WGT_W'($signed(i_s_tdata[85:68]));
            end
            default: begin
                n_s1_use = '0;
            end
        endcase
    end

    // a source slot that an older item still has to write must wait
    always_comb begin
        hazard = 1'b0;
        for (int j = 0; j < N_SRC; j++) begin
            if (r_s1_use[j] && r_s2_vld && r_s2_wr && (r_s2_oidx == r_s1_src[j])) begin
                hazard = 1'b1;
            end
            if (r_s1_use[j] && r_s3_vld && r_s3_wr && (r_s3_oidx == r_s1_src[j])) begin
                hazard = 1'b1;
            end
        end
        hazard = hazard && r_s1_vld;
    end

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_beat) begin
            r_s1_vld <= 1'b1;
        end else if (adv && !hazard) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_src[0]  <= VTX_AW'(i_s_tdata[7:0]);
            r_s1_src[1]  <= VTX_AW'(i_s_tdata[15:8]);
            r_s1_src[2]  <= VTX_AW'(i_s_tdata[23:16]);
            r_s1_use     <= n_s1_use;
            r_s1_wr      <= n_s1_wr;
            r_s1_use_in  <= n_s1_use_in;
            r_s1_oidx    <= n_s1_oidx;
            r_s1_w       <= n_s1_w;
            r_s1_vtx.x     <= i_s_tdata[101:86];
            r_s1_vtx.y     <= i_s_tdata[117:102];
            r_s1_vtx.z     <= i_s_tdata[133:118];
            r_s1_vtx.u     <= i_s_tdata[149:134];
            r_s1_vtx.v     <= i_s_tdata[165:150];
            r_s1_vtx.color <= i_s_tdata[197:166];
        end
    end

    // ---------------------------------------------------------------- store
    assign st_wr.en   = adv && r_s3_vld && r_s3_wr;
    assign st_wr.addr = r_s3_oidx;
    assign st_wr.data = n_res;

    vai_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (adv),
        .i_rd_addr (r_s1_src),
        .i_wr      (st_wr),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------- stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld && !hazard;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_wr     <= r_s1_wr;
            r_s2_use_in <= r_s1_use_in;
            r_s2_oidx   <= r_s1_oidx;
            r_s2_w      <= r_s1_w;
            r_s2_vtx    <= r_s1_vtx;
        end
    end

    // a write rides through the weighting with weight one on the new vertex
    always_comb begin
        s2_src[0] = r_s2_use_in ? r_s2_vtx : rd_data[0];
        s2_src[1] = rd_data[1];
        s2_src[2] = rd_data[2];
        for (int k = 0; k < N_ATTR; k++) begin
            for (int j = 0; j < N_SRC; j++) begin
                n_s3_prod[k][j] = PRD_W'(r_s2_w[j])
                                * PRD_W'(attr_of(s2_src[j], k[3:0]));
            end
        end
    end

    // ---------------------------------------------------------------- stage 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_wr   <= r_s2_wr;
            r_s3_oidx <= r_s2_oidx;
            r_s3_prod <= n_s3_prod;
        end
    end

    always_comb begin
        for (int k = 0; k < N_ATTR; k++) begin
            s3_sum[k] = SUM_W'(r_s3_prod[k][0]) + SUM_W'(r_s3_prod[k][1])
                      + SUM_W'(r_s3_prod[k][2]);
        end
        n_res.x     = to_pos(s3_sum[0]);
        n_res.y     = to_pos(s3_sum[1]);
        n_res.z     = to_pos(s3_sum[2]);
        n_res.u     = to_uv(s3_sum[3]);
        n_res.v     = to_uv(s3_sum[4]);
        n_res.color = {to_chan(s3_sum[8]), to_chan(s3_sum[7]),
                       to_chan(s3_sum[6]), to_chan(s3_sum[5])};
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_oidx <= r_s3_oidx;
            r_out_vtx  <= n_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_vtx.color, r_out_vtx.v, r_out_vtx.u,
                         r_out_vtx.z, r_out_vtx.y, r_out_vtx.x, IDX_W'(r_out_oidx)};

    // ---------------------------------------------------------------- checks
    a_no_write_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_m_tready |-> !st_wr.en)
        else $error("store written while the output beat is stalled");

    a_hazard_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && hazard && adv |=> !r_s2_vld)
        else $error("item passed the store read ahead of a pending write");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_vld |-> o_s_tready)
        else $error("input not ready with an empty input register");

endmodule

`default_nettype wire

@@ rtl/core/vai_store.sv @@
// Vertex store: one write port, three registered read ports (one copy each).
// Per-entry valid bits make never-written entries read as zero. Uses vai_pkg.
`default_nettype none

module vai_store
    import vai_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rd_en,
    input  wire logic [N_SRC-1:0][VTX_AW-1:0]  i_rd_addr,
    input  wire t_store_wr                     i_wr,
    output t_vertex [N_SRC-1:0]                o_rd_data
);

    logic [VERTEX_DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    for (genvar g = 0; g < N_SRC; g++) begin : g_copy
        t_vertex r_mem [VERTEX_DEPTH];
        t_vertex r_rd;
        logic    r_rd_vld;

        always_ff @(posedge i_clk) begin
            if (i_wr.en) begin
                r_mem[i_wr.addr] <= i_wr.data;
            end
            if (i_rd_en) begin
                r_rd     <= r_mem[i_rd_addr[g]];
                r_rd_vld <= r_valid[i_rd_addr[g]];
            end
        end

        assign o_rd_data[g] = r_rd_vld ? r_rd : '0;
    end

endmodule

`default_nettype wire

@@ tb/vertex_attribute_interpolator_checker.sv @@
// Scoreboard for the vertex attribute interpolator: mirrors the vertex store,
// predicts each output beat from the accepted input beats and compares it.
// Depends on vai_pkg.
module vertex_attribute_interpolator_checker
    import vai_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // a_index, b_index, c_index, result_index, weight_a, weight_b, weight_c,
    // in_pos, in_uv, in_color, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // mode
    input  logic [1:0]             i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // out_index, out_pos, out_uv, out_color
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] slot;
        t_vertex    vtx;
    } t_vertex_beat;

    t_vertex      vertex_mirror [VERTEX_DEPTH];
    t_vertex_beat vertex_beats_due [$];
    t_vertex_beat due_beat;
    t_vertex      new_vtx;
    t_mode        beat_mode;
    int           slot_a, slot_b, slot_c, slot_r, slot_out;
    longint       wgt_a, wgt_b, wgt_c;
    int           mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint sx16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    // position: truncate toward zero, saturate
    function automatic logic [15:0] pos_from_sum(longint s);
        longint q;
        q = s / 65536;
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // texture coordinate: nearest, halves upward, saturate
    function automatic logic [15:0] uv_from_sum(longint s);
        longint q;
        q = (s + 32768) >>> 16;
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic logic [7:0] chan_from_sum(longint s);
        longint q;
        q = s + 32768;
        if (q < 0) return 8'd0;
        q = q >>> 16;
        return (q > 255) ? 8'hff : q[7:0];
    endfunction

    function automatic t_vertex blend_vertex(t_vertex va, t_vertex vb, t_vertex vc,
                                             longint wa, longint wb, longint wc);
        t_vertex r;
        r.x = pos_from_sum(wa * sx16(va.x) + wb * sx16(vb.x) + wc * sx16(vc.x));
        r.y = pos_from_sum(wa * sx16(va.y) + wb * sx16(vb.y) + wc * sx16(vc.y));
        r.z = pos_from_sum(wa * sx16(va.z) + wb * sx16(vb.z) + wc * sx16(vc.z));
        r.u = uv_from_sum(wa * sx16(va.u) + wb * sx16(vb.u) + wc * sx16(vc.u));
        r.v = uv_from_sum(wa * sx16(va.v) + wb * sx16(vb.v) + wc * sx16(vc.v));
        for (int k = 0; k < 4; k++) begin
            r.color[8*k +: 8] = chan_from_sum(wa * longint'(va.color[8*k +: 8])
                                            + wb * longint'(vb.color[8*k +: 8])
                                            + wc * longint'(vc.color[8*k +: 8]));
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [47:0] expected_val,
                               logic [47:0] actual_val);
        if (expected_val !== actual_val) begin
            $error("%s: expected %h, got %h", name, expected_val, actual_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vertex_beats_due.delete();
            foreach (vertex_mirror[k]) vertex_mirror[k] = '0;
        end else begin
            // output side first so a stray beat is never matched to one
            // accepted in the same cycle
            if (i_m_tvalid && i_m_tready) begin
                if (vertex_beats_due.size() == 0) begin
                    $error("output beat with no result due: %h", i_m_tdata);
                    mismatches++;
                end else begin
                    due_beat = vertex_beats_due.pop_front();
                    check_field("out_index", 48'(due_beat.slot), 48'(i_m_tdata[7:0]));
                    check_field("out_pos", {due_beat.vtx.z, due_beat.vtx.y, due_beat.vtx.x},
                                i_m_tdata[55:8]);
                    check_field("out_uv", 48'({due_beat.vtx.v, due_beat.vtx.u}),
                                48'(i_m_tdata[87:56]));
                    check_field("out_color", 48'(due_beat.vtx.color),
                                48'(i_m_tdata[119:88]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                beat_mode = t_mode'(i_s_tuser);
                slot_a = int'(i_s_tdata[7:0]) % VERTEX_DEPTH;
                slot_b = int'(i_s_tdata[15:8]) % VERTEX_DEPTH;
                slot_c = int'(i_s_tdata[23:16]) % VERTEX_DEPTH;
                slot_r = int'(i_s_tdata[31:24]) % VERTEX_DEPTH;
                wgt_a  = longint'($signed(i_s_tdata[49:32]));
                wgt_b  = longint'($signed(i_s_tdata[67:50]));
                wgt_c  = longint'($signed(i_s_tdata[85:68]));
                slot_out = slot_r;
                case (beat_mode)
                    MODE_WRITE: begin
                        new_vtx = i_s_tdata[197:86];
                    end
                    MODE_READ: begin
                        new_vtx  = vertex_mirror[slot_a];
                        slot_out = slot_a;
                    end
                    MODE_LERP: begin
                        new_vtx = blend_vertex(vertex_mirror[slot_a], vertex_mirror[slot_b],
                                               vertex_mirror[slot_b], 65536 - wgt_b, wgt_b, 0);
                    end
                    default: begin
                        new_vtx = blend_vertex(vertex_mirror[slot_a], vertex_mirror[slot_b],
                                               vertex_mirror[slot_c], wgt_a, wgt_b, wgt_c);
                    end
                endcase
                // sources were read above, so a result slot equal to a source is fine
                if (beat_mode != MODE_READ) vertex_mirror[slot_r] = new_vtx;
                vertex_beats_due.push_back('{slot: slot_out[7:0], vtx: new_vtx});
            end
        end
        o_pending    <= vertex_beats_due.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/vertex_attribute_interpolator_tb.sv @@
// Testbench top for the vertex attribute interpolator: clock, reset, input
// and output stream drivers and the verdict. Depends on vai_pkg, the block
// and vertex_attribute_interpolator_checker.
module vertex_attribute_interpolator_tb
    import vai_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    wire                    s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // a, b, c, result index, weights a/b/c, pos, uv, color
    logic [1:0]             s_tuser;   // mode
    wire                    m_tvalid;
    logic                   m_tready;
    wire [OUT_TDATA_W-1:0]  m_tdata;   // out_index, out_pos, out_uv, out_color
    int                     fail_count;
    int                     results_pending;
    bit                     idle_on = 1'b1;

    vertex_attribute_interpolator uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    vertex_attribute_interpolator_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("vertex_attribute_interpolator_tb NOT OK");
        $finish;
    end

    // mostly slots 0..7 so that back-to-back items hit the same vertices
    function automatic logic [7:0] pick_slot();
        if ($urandom_range(0, 9) < 6) return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_coord();
        if ($urandom_range(0, 1) != 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 4095)) - 2048);
    endfunction

    task automatic send_beat(t_mode mode, logic [7:0] ia, logic [7:0] ib, logic [7:0] ic,
                             logic [7:0] ir, logic [17:0] wa, logic [17:0] wb,
                             logic [17:0] wc, logic [47:0] pos, logic [31:0] uv,
                             logic [31:0] color);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = mode;
        s_tdata  = {2'b00, color, uv, pos, wc, wb, wa, ir, ic, ib, ia};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // result side: random backpressure per beat
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            stall = idle_on ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial begin
        t_mode       mode;
        logic [17:0] wa, wb, wc;
        int          pick, ka, kb, k;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // store is clear after reset
        send_beat(MODE_READ, 8'd0, 8'd9, 8'd9, 8'd9, 18'h3ffff, 18'h3ffff, 18'h3ffff,
                  '1, '1, '1);
        send_beat(MODE_READ, 8'd255, 8'd0, 8'd0, 8'd0, '0, '0, '0, '0, '0, '0);
        // extreme vertices
        send_beat(MODE_WRITE, 8'hff, 8'hff, 8'hff, 8'd1, 18'h3ffff, 18'h20000, 18'h1ffff,
                  {16'h1234, 16'h8000, 16'h7fff}, {16'h8000, 16'h7fff}, 32'hff00_ff00);
        send_beat(MODE_WRITE, 8'd0, 8'd0, 8'd0, 8'd2, '0, '0, '0,
                  {16'hedcc, 16'h7fff, 16'h8000}, {16'h7fff, 16'h8000}, 32'h00ff_00ff);
        send_beat(MODE_WRITE, 8'd0, 8'd0, 8'd0, 8'd255, '0, '0, '0,
                  48'hffff_ffff_ffff, 32'h0001_ffff, 32'h8040_2010);
        send_beat(MODE_READ, 8'd1, 8'd2, 8'd3, 8'd4, '0, '0, '0, '0, '0, '0);
        send_beat(MODE_READ, 8'd255, 8'd2, 8'd3, 8'd4, '0, '0, '0, '0, '0, '0);
        // lerp: t at zero, one, half, both ends of range, minus one lsb;
        // weight_a and weight_c carry junk that must be ignored
        send_beat(MODE_LERP, 8'd1, 8'd2, 8'd7, 8'd10, 18'h1ffff, 18'h00000, 18'h20000,
                  '1, '1, '1);
        send_beat(MODE_LERP, 8'd1, 8'd2, 8'd7, 8'd11, 18'h2aaaa, 18'h10000, 18'h15555,
                  '0, '0, '0);
        send_beat(MODE_LERP, 8'd1, 8'd2, 8'd7, 8'd12, '0, 18'h08000, '0, '0, '0, '0);
        send_beat(MODE_LERP, 8'd1, 8'd2, 8'd7, 8'd13, '0, 18'h1ffff, '0, '0, '0, '0);
        send_beat(MODE_LERP, 8'd1, 8'd2, 8'd7, 8'd14, '0, 18'h20000, '0, '0, '0, '0);
        send_beat(MODE_LERP, 8'd2, 8'd255, 8'd7, 8'd15, '0, 18'h3ffff, '0, '0, '0, '0);
        // barycentric: thirds, all max, all min, mixed signs, one vertex thrice
        send_beat(MODE_BARY, 8'd1, 8'd2, 8'd255, 8'd20, 18'd21845, 18'd21845, 18'd21846,
                  '0, '0, '0);
        send_beat(MODE_BARY, 8'd1, 8'd2, 8'd255, 8'd21, 18'h1ffff, 18'h1ffff, 18'h1ffff,
                  '0, '0, '0);
        send_beat(MODE_BARY, 8'd1, 8'd2, 8'd255, 8'd22, 18'h20000, 18'h20000, 18'h20000,
                  '0, '0, '0);
        send_beat(MODE_BARY, 8'd1, 8'd2, 8'd255, 8'd23, 18'h10000, 18'h30000, 18'h10000,
                  '0, '0, '0);
        send_beat(MODE_BARY, 8'd2, 8'd2, 8'd2, 8'd24, 18'd21845, 18'd21845, 18'd21846,
                  '0, '0, '0);
        // result slot equal to a source
        send_beat(MODE_BARY, 8'd1, 8'd2, 8'd255, 8'd255, 18'd16384, 18'd16384, 18'd32768,
                  '0, '0, '0);
        send_beat(MODE_READ, 8'd20, 8'd0, 8'd0, 8'd0, '0, '0, '0, '0, '0, '0);
        send_beat(MODE_LERP, 8'd1, 8'd2, 8'd0, 8'd1, '0, 18'd16384, '0, '0, '0, '0);
        send_beat(MODE_READ, 8'd1, 8'd0, 8'd0, 8'd0, '0, '0, '0, '0, '0, '0);
        send_beat(MODE_READ, 8'd200, 8'd0, 8'd0, 8'd200, '1, '1, '1, '1, '1, '1);

        for (int n = 0; n < 550; n++) begin
            // every third stretch runs with no idling on either side
            idle_on = ((n / 60) % 3) != 2;
            pick = $urandom_range(0, 99);
            mode = (pick < 25) ? MODE_WRITE : (pick < 45) ? MODE_READ :
                   (pick < 70) ? MODE_LERP : MODE_BARY;
            wa = 18'($urandom);
            wb = 18'($urandom);
            wc = 18'($urandom);
            if ($urandom_range(0, 3) != 0) begin
                // weights summing to about one, as for points inside a triangle
                ka = $urandom_range(0, 65536);
                kb = $urandom_range(0, 65536 - ka);
                if (mode == MODE_LERP) begin
                    wb = 18'(int'($urandom_range(0, 65536)));
                end else begin
                    wa = 18'(ka + int'($urandom_range(0, 1024)) - 512);
                    wb = 18'(kb);
                    wc = 18'(65536 - ka - kb);
                end
            end
            send_beat(mode, pick_slot(), pick_slot(), pick_slot(), pick_slot(), wa, wb, wc,
                      {pick_coord(), pick_coord(), pick_coord()},
                      {pick_coord(), pick_coord()}, $urandom);
        end
        idle_on = 1'b1;
        @(negedge clk);
        s_tvalid = 1'b0;

        for (k = 0; k < 5000 && results_pending != 0; k++) @(posedge clk);
        repeat (8) @(posedge clk);
        if (results_pending != 0) $error("%0d results never arrived", results_pending);
        if (fail_count == 0 && results_pending == 0) begin
            $display("vertex_attribute_interpolator_tb OK");
        end else begin
            $display("vertex_attribute_interpolator_tb NOT OK");
        end
        $finish;
    end

endmodule
